[rtl/amq_pkg.sv]
package amq_pkg;

	localparam int DEF_MAX_ACCOUNTS    = 16;
	localparam int DEF_MAX_MESSAGES    = 256;
	localparam int DEF_PRIORITY_LEVELS = 16;

	localparam int MODE_W   = 2;
	localparam int ID_W     = 16;
	localparam int PRIO_W   = 4;
	localparam int HANDLE_W = 16;
	localparam int STATUS_W = 4;

	typedef enum logic [MODE_W-1:0] {
		MODE_ADD     = 2'd0,
		MODE_REMOVE  = 2'd1,
		MODE_SEND    = 2'd2,
		MODE_CONSULT = 2'd3
	} amq_mode_t;

	typedef enum logic [STATUS_W-1:0] {
		STS_ADDED      = 4'd0,
		STS_EXISTS     = 4'd1,
		STS_REMOVED    = 4'd2,
		STS_NO_ACCOUNT = 4'd3,
		STS_DELIVERED  = 4'd4,
		STS_EMPTY      = 4'd5,
		STS_POPPED     = 4'd6,
		STS_ACC_FULL   = 4'd7,
		STS_STORE_FULL = 4'd8
	} amq_status_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_EXEC,
		ST_SEARCH,
		ST_PACK,
		ST_FIN
	} amq_state_t;

	// operation broadcast to every cell of the message row
	typedef enum logic [2:0] {
		COP_HOLD,
		COP_INSERT,
		COP_DROP,
		COP_SEARCH,
		COP_PACK
	} amq_cop_t;

	typedef struct packed {
		logic                v;
		logic [PRIO_W-1:0]   prio;
		logic [HANDLE_W-1:0] handle;
	} amq_ent_t;

	typedef struct packed {
		amq_cop_t            op;
		logic [PRIO_W-1:0]   prio;
		logic [HANDLE_W-1:0] handle;
	} amq_ctl_t;

	typedef struct packed {
		logic                tok;
		logic                found;
		logic [HANDLE_W-1:0] handle;
	} amq_tok_t;

	typedef struct packed {
		logic hit;
		logic full;
	} amq_look_t;

	typedef struct packed {
		logic add;
		logic del;
	} amq_acmd_t;

endpackage

[rtl/amq_if.sv]
interface amq_cmd_if import amq_pkg::*; ();
	logic                valid;
	logic                ready;
	logic [MODE_W-1:0]   mode;
	logic [ID_W-1:0]     account_id;
	logic [PRIO_W-1:0]   priority_req;
	logic [HANDLE_W-1:0] message_handle;

	modport source (output valid, output mode, output account_id, output priority_req,
		output message_handle, input ready);
	modport sink (input valid, input mode, input account_id, input priority_req,
		input message_handle, output ready);
endinterface

interface amq_rsp_if import amq_pkg::*; ();
	logic                valid;
	logic                ready;
	logic [STATUS_W-1:0] status;
	logic [HANDLE_W-1:0] message_out;

	modport source (output valid, output status, output message_out, input ready);
	modport sink (input valid, input status, input message_out, output ready);
endinterface

[rtl/amq_cell.sv]
module amq_cell import amq_pkg::*; #(
	parameter int SLOT_W = 4
) (
	input  logic              clk,
	input  logic              arst_n,
	input  amq_ctl_t          ctl,
	input  logic [SLOT_W-1:0] key_slot,
	input  amq_ent_t          l_ent,
	input  logic [SLOT_W-1:0] l_slot,
	input  logic              l_g,
	input  amq_ent_t          r_ent,
	input  logic [SLOT_W-1:0] r_slot,
	input  amq_tok_t          tok_in,
	output amq_ent_t          ent,
	output logic [SLOT_W-1:0] slot,
	output logic              g,
	output amq_tok_t          tok_out
);

	logic                v_q, v_d;
	logic [PRIO_W-1:0]   prio_q, prio_d;
	logic [HANDLE_W-1:0] handle_q, handle_d;
	logic [SLOT_W-1:0]   slot_q, slot_d;
	logic                tok_q, tok_found_q;
	logic [HANDLE_W-1:0] tok_handle_q;
	logic                match, hit;

	assign match = v_q && (slot_q == key_slot);
	// insertion point: empty or lower priority; equal priority stays ahead
	assign g     = !v_q || (prio_q < ctl.prio);
	assign hit   = (ctl.op == COP_SEARCH) && tok_q && !tok_found_q && match;

	assign ent     = '{v: v_q, prio: prio_q, handle: handle_q};
	assign slot    = slot_q;
	assign tok_out = '{tok: tok_q, found: tok_found_q || hit,
		handle: hit ? handle_q : tok_handle_q};

	always_comb begin
		v_d      = v_q;
		prio_d   = prio_q;
		handle_d = handle_q;
		slot_d   = slot_q;
		case (ctl.op)
			COP_INSERT: begin
				if (g && !l_g) begin
					v_d      = 1'b1;
					prio_d   = ctl.prio;
					handle_d = ctl.handle;
					slot_d   = key_slot;
				end else if (l_g) begin
					v_d      = l_ent.v;
					prio_d   = l_ent.prio;
					handle_d = l_ent.handle;
					slot_d   = l_slot;
				end
			end
			COP_DROP: begin
				if (match) begin
					v_d = 1'b0;
				end
			end
			COP_SEARCH: begin
				if (hit) begin
					v_d = 1'b0;
				end
			end
			COP_PACK: begin
				if (!v_q) begin
					v_d      = r_ent.v;
					prio_d   = r_ent.prio;
					handle_d = r_ent.handle;
					slot_d   = r_slot;
				end else if (!l_ent.v) begin
					v_d = 1'b0;
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q   <= 1'b0;
			tok_q <= 1'b0;
		end else begin
			v_q   <= v_d;
			tok_q <= tok_in.tok;
		end
	end

	always_ff @(posedge clk) begin
		prio_q       <= prio_d;
		handle_q     <= handle_d;
		slot_q       <= slot_d;
		tok_found_q  <= tok_in.found;
		tok_handle_q <= tok_in.handle;
	end

endmodule

[rtl/amq_acct.sv]
module amq_acct import amq_pkg::*; #(
	parameter int MAX_ACCOUNTS = DEF_MAX_ACCOUNTS,
	parameter int SLOT_W       = 4
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic [ID_W-1:0]   id,
	input  amq_acmd_t         acmd,
	input  logic [SLOT_W-1:0] del_slot,
	output amq_look_t         look,
	output logic [SLOT_W-1:0] hit_slot
);

	logic [MAX_ACCOUNTS-1:0] valid_q;
	logic [ID_W-1:0]         ident_q [MAX_ACCOUNTS];
	logic [SLOT_W-1:0]       free_slot;

	// lowest matching slot and lowest free slot
	always_comb begin
		look.hit  = 1'b0;
		hit_slot  = '0;
		free_slot = '0;
		for (int i = MAX_ACCOUNTS - 1; i >= 0; i--) begin
			if (valid_q[i] && (ident_q[i] == id)) begin
				look.hit = 1'b1;
				hit_slot = SLOT_W'(i);
			end
			if (!valid_q[i]) begin
				free_slot = SLOT_W'(i);
			end
		end
		look.full = &valid_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else begin
			if (acmd.add) begin
				valid_q[free_slot] <= 1'b1;
			end
			if (acmd.del) begin
				valid_q[del_slot] <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (acmd.add) begin
			ident_q[free_slot] <= id;
		end
	end

endmodule

[rtl/account_mailbox_priority_queue.sv]
// channel | dir | fields                                        | request taken when
// cmd     | in  | mode, account_id, priority_req, message_handle | cmd.valid && cmd.ready
// rsp     | out | status, message_out                           | rsp.valid && rsp.ready
//
// add, send and any unknown-account request: execute, then the result is registered onto rsp
// remove: execute, then a compaction pass over the message row
// consult: execute, then a search token sweep through every cell; when a message is popped,
//   a compaction pass follows
// reset (arst_n low) empties the account table and the message row at once
// a new request is taken while an earlier result still waits on rsp
module account_mailbox_priority_queue import amq_pkg::*; #(
	parameter int MAX_ACCOUNTS    = DEF_MAX_ACCOUNTS,
	parameter int MAX_MESSAGES    = DEF_MAX_MESSAGES,
	parameter int PRIORITY_LEVELS = DEF_PRIORITY_LEVELS
) (
	input  logic     clk,
	input  logic     arst_n,
	amq_cmd_if.sink   cmd,
	amq_rsp_if.source rsp
);

	localparam int SLOT_W   = (MAX_ACCOUNTS > 1) ? $clog2(MAX_ACCOUNTS) : 1;
	localparam int PK_W     = $clog2(MAX_MESSAGES);
	localparam int PRIO_TOP = (PRIORITY_LEVELS - 1 > (1 << PRIO_W) - 1) ?
		(1 << PRIO_W) - 1 : PRIORITY_LEVELS - 1;

	amq_state_t          state_q, state_d;
	amq_mode_t           mode_q;
	logic [ID_W-1:0]     id_q;
	logic [PRIO_W-1:0]   prio_q;
	logic [HANDLE_W-1:0] handle_q;
	logic [SLOT_W-1:0]   slot_q;
	logic [PK_W-1:0]     pk_q;
	amq_status_t         sts_q, exec_sts;
	logic [HANDLE_W-1:0] msg_q;
	logic                rsp_valid_q;
	amq_status_t         rsp_status_q;
	logic [HANDLE_W-1:0] rsp_msg_q;

	// account table
	amq_look_t         look;
	logic [SLOT_W-1:0] hit_slot;
	amq_acmd_t         acmd;

	// message row
	amq_ctl_t              ctl;
	logic [SLOT_W-1:0]     key_slot;
	logic                  inject;
	amq_ent_t              ent_w  [MAX_MESSAGES];
	logic [SLOT_W-1:0]     slot_w [MAX_MESSAGES];
	logic                  g_w    [MAX_MESSAGES];
	amq_tok_t              tok_w  [MAX_MESSAGES];
	logic [MAX_MESSAGES-1:0] ent_v;
	amq_tok_t              tok_end;
	logic                  store_full;
	logic                  pk_done, rsp_free;

	amq_acct #(
		.MAX_ACCOUNTS(MAX_ACCOUNTS),
		.SLOT_W      (SLOT_W)
	) u_acct (
		.clk     (clk),
		.arst_n  (arst_n),
		.id      (id_q),
		.acmd    (acmd),
		.del_slot(hit_slot),
		.look    (look),
		.hit_slot(hit_slot)
	);

	// row of cells, kept sorted by priority (stable) and packed toward cell 0
	for (genvar j = 0; j < MAX_MESSAGES; j++) begin : g_cell
		amq_ent_t          l_ent, r_ent;
		logic [SLOT_W-1:0] l_slot, r_slot;
		logic              l_g;
		amq_tok_t          tok_in;

		if (j == 0) begin : g_first
			assign l_ent  = '{v: 1'b1, prio: '0, handle: '0};
			assign l_slot = '0;
			assign l_g    = 1'b0;
			assign tok_in = '{tok: inject, found: 1'b0, handle: '0};
		end else begin : g_mid
			assign l_ent  = ent_w[j-1];
			assign l_slot = slot_w[j-1];
			assign l_g    = g_w[j-1];
			assign tok_in = tok_w[j-1];
		end

		if (j == MAX_MESSAGES - 1) begin : g_last
			assign r_ent  = '{v: 1'b0, prio: '0, handle: '0};
			assign r_slot = '0;
		end else begin : g_inner
			assign r_ent  = ent_w[j+1];
			assign r_slot = slot_w[j+1];
		end

		amq_cell #(
			.SLOT_W(SLOT_W)
		) u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.ctl     (ctl),
			.key_slot(key_slot),
			.l_ent   (l_ent),
			.l_slot  (l_slot),
			.l_g     (l_g),
			.r_ent   (r_ent),
			.r_slot  (r_slot),
			.tok_in  (tok_in),
			.ent     (ent_w[j]),
			.slot    (slot_w[j]),
			.g       (g_w[j]),
			.tok_out (tok_w[j])
		);

		assign ent_v[j] = ent_w[j].v;
	end

	assign tok_end    = tok_w[MAX_MESSAGES-1];
	// row is packed, so the store is full exactly when the last cell holds a message
	assign store_full = ent_w[MAX_MESSAGES-1].v;
	assign pk_done    = (pk_q == PK_W'(MAX_MESSAGES - 1));
	assign rsp_free   = !rsp_valid_q || rsp.ready;
	assign key_slot   = (state_q == ST_EXEC) ? hit_slot : slot_q;

	// status decided in the execute cycle (a consult's is replaced by the search outcome)
	always_comb begin
		if (mode_q == MODE_ADD) begin
			if (look.hit) begin
				exec_sts = STS_EXISTS;
			end else if (look.full) begin
				exec_sts = STS_ACC_FULL;
			end else begin
				exec_sts = STS_ADDED;
			end
		end else if (!look.hit) begin
			exec_sts = STS_NO_ACCOUNT;
		end else begin
			case (mode_q)
				MODE_REMOVE: exec_sts = STS_REMOVED;
				MODE_SEND:   exec_sts = store_full ? STS_STORE_FULL : STS_DELIVERED;
				default:     exec_sts = STS_EMPTY;
			endcase
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (cmd.valid) begin
					state_d = ST_EXEC;
				end
			end
			ST_EXEC: begin
				if (mode_q == MODE_ADD || !look.hit || mode_q == MODE_SEND) begin
					state_d = ST_FIN;
				end else if (mode_q == MODE_REMOVE) begin
					state_d = ST_PACK;
				end else begin
					state_d = ST_SEARCH;
				end
			end
			ST_SEARCH: begin
				if (tok_end.tok) begin
					state_d = tok_end.found ? ST_PACK : ST_FIN;
				end
			end
			ST_PACK: begin
				if (pk_done) begin
					state_d = ST_FIN;
				end
			end
			ST_FIN: begin
				if (rsp_free) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// outputs of the sequencer
	always_comb begin
		cmd.ready  = (state_q == ST_IDLE);
		acmd       = '{add: 1'b0, del: 1'b0};
		ctl        = '{op: COP_HOLD, prio: prio_q, handle: handle_q};
		inject     = 1'b0;
		case (state_q)
			ST_EXEC: begin
				if (mode_q == MODE_ADD) begin
					acmd.add = !look.hit && !look.full;
				end else if (look.hit) begin
					case (mode_q)
						MODE_REMOVE: begin
							acmd.del = 1'b1;
							ctl.op   = COP_DROP;
						end
						MODE_SEND: begin
							if (!store_full) begin
								ctl.op = COP_INSERT;
							end
						end
						default: begin
							inject = 1'b1;
						end
					endcase
				end
			end
			ST_SEARCH: ctl.op = COP_SEARCH;
			ST_PACK:   ctl.op = COP_PACK;
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			rsp_valid_q <= 1'b0;
			pk_q        <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_PACK) begin
				pk_q <= pk_q + 1'b1;
			end else begin
				pk_q <= '0;
			end
			if (state_q == ST_FIN && rsp_free) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		// capture the request, with priority saturated to the top level
		if (cmd.valid && cmd.ready) begin
			mode_q   <= amq_mode_t'(cmd.mode);
			id_q     <= cmd.account_id;
			handle_q <= cmd.message_handle;
			if (32'(cmd.priority_req) > PRIO_TOP) begin
				prio_q <= PRIO_W'(PRIO_TOP);
			end else begin
				prio_q <= cmd.priority_req;
			end
		end
		if (state_q == ST_EXEC) begin
			sts_q  <= exec_sts;
			msg_q  <= '0;
			slot_q <= hit_slot;
		end
		// token leaving the last cell carries the search outcome
		if (state_q == ST_SEARCH && tok_end.tok) begin
			sts_q <= tok_end.found ? STS_POPPED : STS_EMPTY;
			msg_q <= tok_end.found ? tok_end.handle : '0;
		end
		if (state_q == ST_FIN && rsp_free) begin
			rsp_status_q <= sts_q;
			rsp_msg_q    <= msg_q;
		end
	end

	assign rsp.valid       = rsp_valid_q;
	assign rsp.status      = rsp_status_q;
	assign rsp.message_out = rsp_msg_q;

	// a taken request always moves to the execute cycle
	a_accept_exec: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.valid && cmd.ready) |=> (state_q == ST_EXEC))
		else $error("request taken without entering execute");

	// message row packed whenever no request is in flight
	a_row_packed: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE) |-> (((ent_v >> 1) & ~ent_v) == '0))
		else $error("message row has a hole while idle");

	// search token only leaves the row during a search
	a_token_search: assert property (@(posedge clk) disable iff (!arst_n)
		tok_end.tok |-> (state_q == ST_SEARCH))
		else $error("search token outside a search");

	// handle is zero unless a message was popped
	a_msg_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp.valid && (rsp.status != STS_POPPED)) |-> (rsp.message_out == '0))
		else $error("message handle on a non-pop result");

endmodule

[tb/tb_account_mailbox_priority_queue.sv]
`timescale 1ns / 1ps

module tb_account_mailbox_priority_queue;
	import amq_pkg::*;

	localparam int N_ACCT = DEF_MAX_ACCOUNTS;
	localparam int N_MSG  = DEF_MAX_MESSAGES;
	localparam int N_PRIO = DEF_PRIORITY_LEVELS;
	localparam int N_RAND = 430;
	localparam int DRAIN_CYCLES = 2 * N_MSG + 20;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	always #2 clk = ~clk;

	amq_cmd_if cmd ();
	amq_rsp_if rsp ();

	account_mailbox_priority_queue dut (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd.sink),
		.rsp    (rsp.source)
	);

	// mirror of the mailbox: per-account ordered lists of (priority, handle)
	typedef struct packed {
		logic [PRIO_W-1:0]   prio;
		logic [HANDLE_W-1:0] handle;
	} msg_t;

	typedef struct packed {
		amq_status_t         status;
		logic [HANDLE_W-1:0] message_out;
	} reply_t;

	typedef struct packed {
		amq_mode_t           mode;
		logic [ID_W-1:0]     account_id;
		logic [PRIO_W-1:0]   priority_req;
		logic [HANDLE_W-1:0] message_handle;
		logic                has_fixed;
		amq_status_t         fixed_status;
	} row_t;

	logic            acct_used [N_ACCT];
	logic [ID_W-1:0] acct_ident [N_ACCT];
	msg_t            mbox [N_ACCT][$];
	int              msgs_stored;

	reply_t expected_replies [$];
	int     fail_count;
	int     replies_seen;
	bit     idle_enable;
	bit     hold_rsp;
	bit     stim_done;
	int     status_hits [16];

	function automatic int find_slot(logic [ID_W-1:0] id);
		for (int i = 0; i < N_ACCT; i++)
			if (acct_used[i] && acct_ident[i] == id)
				return i;
		return -1;
	endfunction

	// advances the mirror by one request and returns the reply it should give
	function automatic reply_t apply_request(amq_mode_t mode, logic [ID_W-1:0] id,
		logic [PRIO_W-1:0] prio_in, logic [HANDLE_W-1:0] handle);
		reply_t r;
		int slot;
		int pos;
		logic [PRIO_W-1:0] prio;
		msg_t m;
		r.message_out = '0;
		slot = find_slot(id);
		// saturate to the top level when the priority range is narrower than the field
		prio = (prio_in > N_PRIO - 1) ? PRIO_W'(N_PRIO - 1) : prio_in;
		if (mode == MODE_ADD) begin
			if (slot >= 0) begin
				r.status = STS_EXISTS;
			end else begin
				r.status = STS_ACC_FULL;
				for (int i = 0; i < N_ACCT; i++) begin
					if (!acct_used[i]) begin
						acct_used[i] = 1'b1;
						acct_ident[i] = id;
						mbox[i].delete();
						r.status = STS_ADDED;
						break;
					end
				end
			end
		end else if (slot < 0) begin
			r.status = STS_NO_ACCOUNT;
		end else if (mode == MODE_REMOVE) begin
			// queued messages go back to the shared store
			msgs_stored -= mbox[slot].size();
			mbox[slot].delete();
			acct_used[slot] = 1'b0;
			r.status = STS_REMOVED;
		end else if (mode == MODE_SEND) begin
			if (msgs_stored >= N_MSG) begin
				r.status = STS_STORE_FULL;
			end else begin
				// stable insert: behind every entry of equal or higher priority
				pos = 0;
				while (pos < mbox[slot].size() && mbox[slot][pos].prio >= prio)
					pos++;
				m.prio = prio;
				m.handle = handle;
				mbox[slot].insert(pos, m);
				msgs_stored++;
				r.status = STS_DELIVERED;
			end
		end else begin
			if (mbox[slot].size() == 0) begin
				r.status = STS_EMPTY;
			end else begin
				m = mbox[slot].pop_front();
				msgs_stored--;
				r.message_out = m.handle;
				r.status = STS_POPPED;
			end
		end
		return r;
	endfunction

	// directed rows: fixed status only where it is plain from the command history
	row_t dir_rows [] = '{
		'{MODE_CONSULT, 16'h0000, 4'h0, 16'h0000, 1'b1, STS_NO_ACCOUNT},
		'{MODE_REMOVE,  16'hffff, 4'h0, 16'h0000, 1'b1, STS_NO_ACCOUNT},
		'{MODE_SEND,    16'h1234, 4'hf, 16'hffff, 1'b1, STS_NO_ACCOUNT},
		'{MODE_ADD,     16'h0000, 4'h0, 16'h0000, 1'b1, STS_ADDED},
		'{MODE_ADD,     16'hffff, 4'hf, 16'hffff, 1'b1, STS_ADDED},
		'{MODE_ADD,     16'h0000, 4'h0, 16'h0000, 1'b1, STS_EXISTS},
		'{MODE_CONSULT, 16'hffff, 4'h0, 16'h0000, 1'b1, STS_EMPTY},
		'{MODE_SEND,    16'hffff, 4'h3, 16'haaaa, 1'b1, STS_DELIVERED},
		'{MODE_SEND,    16'hffff, 4'hf, 16'h5555, 1'b1, STS_DELIVERED},
		'{MODE_SEND,    16'hffff, 4'h3, 16'h0001, 1'b1, STS_DELIVERED},
		'{MODE_SEND,    16'hffff, 4'h0, 16'hffff, 1'b1, STS_DELIVERED},
		'{MODE_SEND,    16'hffff, 4'hf, 16'h0000, 1'b1, STS_DELIVERED},
		'{MODE_CONSULT, 16'hffff, 4'h0, 16'h0000, 1'b0, STS_POPPED},
		'{MODE_CONSULT, 16'hffff, 4'h0, 16'h0000, 1'b0, STS_POPPED},
		'{MODE_CONSULT, 16'hffff, 4'h0, 16'h0000, 1'b0, STS_POPPED},
		'{MODE_SEND,    16'h0000, 4'h7, 16'hbeef, 1'b1, STS_DELIVERED},
		'{MODE_SEND,    16'h0000, 4'h7, 16'hcafe, 1'b1, STS_DELIVERED},
		// remove with messages still queued
		'{MODE_REMOVE,  16'hffff, 4'h0, 16'h0000, 1'b1, STS_REMOVED},
		'{MODE_CONSULT, 16'hffff, 4'h0, 16'h0000, 1'b1, STS_NO_ACCOUNT},
		'{MODE_CONSULT, 16'h0000, 4'h0, 16'h0000, 1'b0, STS_POPPED},
		'{MODE_REMOVE,  16'h0000, 4'h0, 16'h0000, 1'b1, STS_REMOVED}
	};

	// send one request, idling beforehand now and then
	task automatic put_request(amq_mode_t mode, logic [ID_W-1:0] id,
		logic [PRIO_W-1:0] prio, logic [HANDLE_W-1:0] handle, bit has_fixed,
		amq_status_t fixed_status);
		reply_t r;
		int gap;
		if (idle_enable && $urandom_range(0, 3) == 0) begin
			gap = $urandom_range(1, 6);
			cmd.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		cmd.valid <= 1'b1;
		cmd.mode <= mode;
		cmd.account_id <= id;
		cmd.priority_req <= prio;
		cmd.message_handle <= handle;
		@(posedge clk);
		while (!cmd.ready)
			@(posedge clk);
		// request taken at this edge: predict in order of acceptance
		r = apply_request(mode, id, prio, handle);
		if (has_fixed && r.status != fixed_status) begin
			$error("directed row: status expected %0d, predictor gives %0d",
				fixed_status, r.status);
			fail_count++;
		end
		expected_replies.push_back(r);
	endtask

	function automatic logic [ID_W-1:0] pick_id();
		int slot;
		// mostly known ids, sometimes fresh random ones
		if ($urandom_range(0, 9) < 8) begin
			slot = $urandom_range(0, N_ACCT - 1);
			if (acct_used[slot])
				return acct_ident[slot];
			return ID_W'($urandom_range(0, 23));
		end
		return ID_W'($urandom());
	endfunction

	// sender
	initial begin
		amq_mode_t mode;
		int pick;
		cmd.valid = 1'b0;
		cmd.mode = MODE_ADD;
		cmd.account_id = '0;
		cmd.priority_req = '0;
		cmd.message_handle = '0;
		stim_done = 1'b0;
		idle_enable = 1'b1;
		msgs_stored = 0;
		for (int i = 0; i < N_ACCT; i++) begin
			acct_used[i] = 1'b0;
			acct_ident[i] = '0;
		end
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (dir_rows[i])
			put_request(dir_rows[i].mode, dir_rows[i].account_id, dir_rows[i].priority_req,
				dir_rows[i].message_handle, dir_rows[i].has_fixed, dir_rows[i].fixed_status);

		// fill the account table past capacity
		for (int i = 0; i < N_ACCT + 2; i++)
			put_request(MODE_ADD, ID_W'(i), 4'h0, 16'h0000, 1'b0, STS_ADDED);

		for (int n = 0; n < N_RAND; n++) begin
			if (n > N_RAND - 60)
				idle_enable = 1'b0;
			// a send-heavy stretch drives the shared store full
			if (n >= 40 && n < 370)
				pick = 50;
			else
				pick = $urandom_range(0, 99);
			if (pick < 8)
				mode = MODE_ADD;
			else if (pick < 13)
				mode = MODE_REMOVE;
			else if (pick < 60)
				mode = MODE_SEND;
			else
				mode = MODE_CONSULT;
			put_request(mode, pick_id(), PRIO_W'($urandom()), HANDLE_W'($urandom()),
				1'b0, STS_ADDED);
		end
		cmd.valid <= 1'b0;
		stim_done = 1'b1;
	end

	// receiver: random stalls plus one long hold-off so the input backs up
	initial begin
		int gap;
		rsp.ready = 1'b0;
		hold_rsp = 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (replies_seen >= 30 && !hold_rsp) begin
				hold_rsp = 1'b1;
				rsp.ready <= 1'b0;
				repeat (3000) @(posedge clk);
				rsp.ready <= 1'b1;
			end else if (idle_enable && $urandom_range(0, 4) == 0) begin
				gap = $urandom_range(1, 6);
				rsp.ready <= 1'b0;
				repeat (gap) @(posedge clk);
				rsp.ready <= 1'b1;
			end else begin
				rsp.ready <= 1'b1;
			end
		end
	end

	// reply checker
	always @(posedge clk) begin
		reply_t r;
		if (arst_n && rsp.valid && rsp.ready) begin
			replies_seen++;
			if (expected_replies.size() == 0) begin
				$error("reply with no request pending: status %0d", rsp.status);
				fail_count++;
			end else begin
				r = expected_replies.pop_front();
				status_hits[r.status]++;
				if (rsp.status !== r.status) begin
					$error("status: expected %0d, actual %0d", r.status, rsp.status);
					fail_count++;
				end
				if (rsp.message_out !== r.message_out) begin
					$error("message_out: expected %h, actual %h", r.message_out,
						rsp.message_out);
					fail_count++;
				end
			end
		end
	end

	// end of run
	initial begin
		fail_count = 0;
		replies_seen = 0;
		wait (stim_done);
		while (expected_replies.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		$display("requests answered: %0d; popped %0d, store full %0d, accounts full %0d",
			replies_seen, status_hits[STS_POPPED], status_hits[STS_STORE_FULL],
			status_hits[STS_ACC_FULL]);
		$display("no-account %0d, duplicate adds %0d, removes %0d, empty consults %0d",
			status_hits[STS_NO_ACCOUNT], status_hits[STS_EXISTS],
			status_hits[STS_REMOVED], status_hits[STS_EMPTY]);
		if (fail_count == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

	// watchdog: about 470 requests at the worst-case consult time, plus stalls and the hold-off
	initial begin
		#4000000;
		$display("== FAIL ==");
		$finish;
	end

endmodule
